// ===== src/ogd_pkg.sv =====
`timescale 1ns / 1ps

package ogd_pkg;

   localparam int GRID_SIDE  = 256;
   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int SIDE_W     = $clog2(GRID_SIDE);
   localparam int IDX_W      = $clog2(CELL_COUNT);

   localparam logic [7:0] HIT_MAX = 8'd255;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_DECAY  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] CLASS_EMPTY  = 2'd0;
   localparam logic [1:0] CLASS_LIGHT  = 2'd1;
   localparam logic [1:0] CLASS_STRONG = 2'd2;

   localparam logic [2:0] CSR_LIGHT_THR  = 3'd0;
   localparam logic [2:0] CSR_STRONG_THR = 3'd1;
   localparam logic [2:0] CSR_EMPTY_VAL  = 3'd2;
   localparam logic [2:0] CSR_LIGHT_VAL  = 3'd3;
   localparam logic [2:0] CSR_STRONG_VAL = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] column;
      logic signed [15:0] row;
      logic [7:0]         weight;
      logic [2:0]         source_tag;
   } req_type;

   typedef struct packed {
      logic       in_range;
      logic [7:0] hit_count;
      logic [7:0] cell_value;
      logic [2:0] cell_source;
   } rsp_type;

   typedef struct packed {
      logic [7:0] hit;
      logic [1:0] cls;
      logic [2:0] src;
   } cell_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic decay_rd;
      logic walk_arm;
      logic reread;
      logic modify;
      logic cnt_step;
   } cmd_type;

   typedef struct packed {
      logic req_decay;
      logic cnt_last;
      logic out_free;
   } sts_type;

   function automatic logic [1:0] classify(input logic [7:0] hits, input logic [7:0] light_thr,
                                           input logic [7:0] strong_thr);
      logic [1:0] cls;
      priority if (hits >= strong_thr) begin
         cls = CLASS_STRONG;
      end else if (hits >= light_thr) begin
         cls = CLASS_LIGHT;
      end else begin
         cls = CLASS_EMPTY;
      end
      return cls;
   endfunction

   function automatic logic [7:0] value_of(input logic [1:0] cls, input logic [7:0] empty_val,
                                           input logic [7:0] light_val,
                                           input logic [7:0] strong_val);
      logic [7:0] val;
      unique case (cls)
         CLASS_STRONG: val = strong_val;
         CLASS_LIGHT:  val = light_val;
         default:      val = empty_val;
      endcase
      return val;
   endfunction

endpackage

// ===== src/ogd_ctrl.sv =====
`timescale 1ns / 1ps

module ogd_ctrl
   import ogd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECAY  = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_REREAD = 3'd4;
   localparam logic [2:0] S_MODIFY = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.req_decay ? S_DECAY : S_MODIFY;
            end
         end
         S_DECAY: begin
            cmd.decay_rd = 1'b1;
            cmd.walk_arm = 1'b1;
            cmd.cnt_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_REREAD;
         end
         S_REREAD: begin
            cmd.reread = 1'b1;
            state_in   = S_MODIFY;
         end
         S_MODIFY: begin
            if (sts.out_free) begin
               cmd.modify = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_modify_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY && !sts.out_free) |=> (state_ff == S_MODIFY))
      else $error("result lost while output busy");

   a_walk_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECAY && sts.cnt_last) |=> (state_ff == S_DRAIN))
      else $error("decay walk did not drain");

   a_clear_first: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == S_CLEAR || reset))
      else $error("clearing pass skipped after reset");

   a_reread_feeds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REREAD) |=> (state_ff == S_MODIFY))
      else $error("reread not followed by result");

endmodule

// ===== src/ogd_dp.sv =====
`timescale 1ns / 1ps

module ogd_dp
   import ogd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cell_type cell_mem [CELL_COUNT];

   logic [7:0] light_thr_ff;
   logic [7:0] strong_thr_ff;
   logic [7:0] empty_val_ff;
   logic [7:0] light_val_ff;
   logic [7:0] strong_val_ff;

   req_type    item_ff;
   logic       ok_ff;
   logic [IDX_W-1:0] addr_ff;
   cell_type   rd_data_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic [IDX_W-1:0] cnt_in;
   logic [IDX_W-1:0] walk_addr_ff;
   logic       walk_wv_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   logic       req_ok;
   logic [IDX_W-1:0] req_idx;
   logic       rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic       wr_en;
   logic [IDX_W-1:0] wr_addr;
   cell_type   wr_data;
   cell_type   decayed;
   cell_type   updated;
   cell_type   result_cell;
   logic [8:0] sum;
   logic [7:0] dec_hit;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         light_thr_ff  <= 8'd2;
         strong_thr_ff <= 8'd6;
         empty_val_ff  <= 8'd0;
         light_val_ff  <= 8'd64;
         strong_val_ff <= 8'd200;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LIGHT_THR:  light_thr_ff  <= csr_wdata;
            CSR_STRONG_THR: strong_thr_ff <= csr_wdata;
            CSR_EMPTY_VAL:  empty_val_ff  <= csr_wdata;
            CSR_LIGHT_VAL:  light_val_ff  <= csr_wdata;
            CSR_STRONG_VAL: strong_val_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // address of the incoming beat
   assign req_ok = !req_payload.column[15] && (req_payload.column < 16'(GRID_SIDE))
                && !req_payload.row[15] && (req_payload.row < 16'(GRID_SIDE));
   assign req_idx = req_ok ? IDX_W'(32'(req_payload.row[SIDE_W-1:0]) * 32'(GRID_SIDE)
                                   + 32'(req_payload.column[SIDE_W-1:0]))
                           : '0;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_payload;
         ok_ff   <= req_ok;
         addr_ff <= req_idx;
      end
   end

   // walk counter
   assign sts.cnt_last = (cnt_ff == IDX_W'(CELL_COUNT - 1));
   assign cnt_in = sts.cnt_last ? '0 : cnt_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         walk_wv_ff <= 1'b0;
      end else begin
         if (cmd.cnt_step) begin
            cnt_ff <= cnt_in;
         end
         walk_wv_ff <= cmd.walk_arm;
      end
   end

   always_ff @(posedge clock) begin
      walk_addr_ff <= cnt_ff;
   end

   // cell arithmetic
   assign dec_hit = rd_data_ff.hit - 8'd1;
   always_comb begin
      if (rd_data_ff.hit == 8'd0) begin
         decayed = '{hit: 8'd0, cls: CLASS_EMPTY, src: 3'd0};
      end else begin
         decayed.hit = dec_hit;
         decayed.cls = classify(dec_hit, light_thr_ff, strong_thr_ff);
         decayed.src = rd_data_ff.src;
      end
   end

   assign sum = {1'b0, rd_data_ff.hit} + {1'b0, item_ff.weight};
   always_comb begin
      updated.hit = sum[8] ? HIT_MAX : sum[7:0];
      updated.cls = classify(updated.hit, light_thr_ff, strong_thr_ff);
      updated.src = (item_ff.source_tag != 3'd0) ? item_ff.source_tag : rd_data_ff.src;
   end

   // memory ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = updated;
      priority if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = '0;
      end else if (walk_wv_ff) begin
         wr_en   = 1'b1;
         wr_addr = walk_addr_ff;
         wr_data = decayed;
      end else if (cmd.modify && ok_ff && item_ff.op == OP_UPDATE) begin
         wr_en = 1'b1;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_comb begin
      rd_en   = cmd.accept || cmd.decay_rd || cmd.reread;
      rd_addr = addr_ff;
      priority if (cmd.accept) begin
         rd_addr = req_idx;
      end else if (cmd.decay_rd) begin
         rd_addr = cnt_ff;
      end else begin
         rd_addr = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   // result register
   assign result_cell = (item_ff.op == OP_UPDATE) ? updated : rd_data_ff;

   always_comb begin
      if (ok_ff) begin
         rsp_in.in_range    = 1'b1;
         rsp_in.hit_count   = result_cell.hit;
         rsp_in.cell_value  = value_of(result_cell.cls, empty_val_ff, light_val_ff,
                                       strong_val_ff);
         rsp_in.cell_source = result_cell.src;
      end else begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.modify) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.modify) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.req_decay = (req_payload.op == OP_DECAY);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(walk_wv_ff && cmd.modify))
      else $error("walk write collides with update write");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.modify |-> sts.out_free)
      else $error("result register overwritten");

   a_out_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.in_range) |-> (rsp_ff.hit_count == 8'd0
         && rsp_ff.cell_source == 3'd0))
      else $error("out of range result carries cell data");

endmodule

// ===== src/occupancy_grid_hit_decay.sv =====
`timescale 1ns / 1ps

// channel  ports                                  beat
// req      req_valid, req_stall, req_payload       op, column, row, weight, source_tag
// rsp      rsp_valid, rsp_stall, rsp_payload       in_range, hit_count, cell_value, cell_source
// csr      csr_write_en, csr_index, csr_wdata      one 8-bit register per write
//
// update and read: one cell memory read, then write-back (update only) as the result is loaded
// decay tick: walks every cell, one cell per cycle through the memory ports
// after reset a clearing pass writes every cell (CELL_COUNT, 65536 cells), req stalled
// a finished result waits in the output register; the next beat is taken meanwhile

module occupancy_grid_hit_decay
   import ogd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   ogd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ogd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule
